[rtl/core/assert_macros.svh]
// Assertion macros shared by the rasterizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked at every clock edge outside reset.
`define CHECK_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("check failed");
// Implication whose property is checked in the cycle after the condition.
`define CHECK_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("check failed");
`endif

[rtl/core/dslr_pkg.sv]
// Package with payload types and constants for the double step line rasterizer.
`timescale 1ns / 1ps
`default_nettype none
package dslr_pkg;
   localparam int CoordBits = 11;
   localparam int ColorBits = 8;
   localparam int AddrBits = 22;
   localparam int StrideBits = 12;
   localparam int DecBits = CoordBits + 5;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_ADVANCE = 1'b1;

   typedef enum logic [3:0] {
      MODE_IDLE     = 4'b0001,
      MODE_STRAIGHT = 4'b0010,
      MODE_SHALLOW  = 4'b0100,
      MODE_STEEP    = 4'b1000
   } mode_type;

   typedef struct packed {
      logic                 op;
      logic [CoordBits-1:0] x_start;
      logic [CoordBits-1:0] y_start;
      logic [CoordBits-1:0] x_end;
      logic [CoordBits-1:0] y_end;
      logic [ColorBits-1:0] color;
   } req_type;

   typedef struct packed {
      logic [CoordBits-1:0] pixel_x;
      logic [CoordBits-1:0] pixel_y;
      logic [AddrBits-1:0]  pixel_address;
      logic [ColorBits-1:0] pixel_color;
      logic                 last;
      logic                 line_done;
   } rsp_type;

   // One pixel to address, before the address multiply.
   typedef struct packed {
      logic [CoordBits-1:0] x;
      logic [CoordBits-1:0] y;
      logic [ColorBits-1:0] color;
      logic                 last;
      logic                 line_done;
   } pix_type;
endpackage
`default_nettype wire

[rtl/core/dslr_step.sv]
// Line walker: state registers and the per-item pixel generation.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module dslr_step (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   in_valid,
   input  dslr_pkg::req_type     in_data,
   output logic                  in_stall,
   output logic                  px_valid,
   output dslr_pkg::pix_type     px_data,
   input  wire                   px_stall
);
   import dslr_pkg::*;

   typedef logic [CoordBits-1:0] crd_type;
   typedef logic signed [DecBits-1:0] dec_type;

   // Line state.
   crd_type fm_ff, fn_ff, bm_ff, bn_ff;
   dec_type dec_ff, inc1_ff, inc2_ff, thr_ff;
   logic neg_ff, swap_ff;
   logic [CoordBits-3:0] grp_ff;
   logic [1:0] tail_ff;
   mode_type mode_ff;
   logic [ColorBits-1:0] col_ff;

   // Pending pixels of the current item, emitted one per cycle while px_stall is low.
   pix_type buf_ff [4];
   logic [2:0] cnt_ff;
   logic [1:0] idx_ff;

   crd_type fm_in, fn_in, bm_in, bn_in;
   dec_type dec_in, inc1_in, inc2_in, thr_in;
   logic neg_in, swap_in;
   logic [CoordBits-3:0] grp_in;
   logic [1:0] tail_in;
   mode_type mode_in;
   logic [ColorBits-1:0] col_in;
   pix_type pix [4];
   logic [2:0] n;

   logic busy, take, pop;
   assign busy = (cnt_ff != 3'd0);
   assign pop = busy && !px_stall;
   // A new item enters when nothing is pending or the pending buffer empties this cycle.
   assign in_stall = busy && !(pop && cnt_ff == 3'd1);
   assign take = in_valid && !in_stall;

   assign px_valid = busy;
   assign px_data = buf_ff[idx_ff];

   function automatic pix_type mk(input logic sw, input crd_type ma, input crd_type mi,
                                  input logic [ColorBits-1:0] c, input logic dn);
      pix_type p;
      p.x = sw ? mi : ma;
      p.y = sw ? ma : mi;
      p.color = c;
      p.last = 1'b0;
      p.line_done = dn;
      return p;
   endfunction

   // Next state and the pixels of the accepted item.
   always_comb begin
      crd_type a1, b1, a2, b2, dxa, dya, t, fm1, fn1, fm2, fn2, bm1, bn1, bm2, bn2, bng;
      logic sx, sy, f1, f2, g, fin, up, dn2, dn3;
      logic [3:0] pat;
      logic [CoordBits:0] dxs, dys;
      dec_type d4, i2;
      fm_in = fm_ff; fn_in = fn_ff; bm_in = bm_ff; bn_in = bn_ff;
      dec_in = dec_ff; inc1_in = inc1_ff; inc2_in = inc2_ff; thr_in = thr_ff;
      neg_in = neg_ff; swap_in = swap_ff; grp_in = grp_ff; tail_in = tail_ff;
      mode_in = mode_ff; col_in = col_ff; n = 3'd0;
      for (int k = 0; k < 4; k++) pix[k] = '0;
      a1 = in_data.x_start; b1 = in_data.y_start;
      a2 = in_data.x_end; b2 = in_data.y_end;
      sx = 1'b0; sy = 1'b0; dxa = '0; dya = '0; t = '0; fin = 1'b0; bng = '0;
      dxs = '0; dys = '0; d4 = '0; i2 = '0; g = 1'b0; dn2 = 1'b0; dn3 = 1'b0;
      // Pattern select: one-hot flat-flat, flat-step, step-flat, step-step.
      if (mode_ff == MODE_SHALLOW && dec_ff < 0) pat = 4'b0001;
      else if (mode_ff == MODE_STEEP && dec_ff > 0) pat = 4'b1000;
      else if (dec_ff < thr_ff) pat = 4'b0010;
      else pat = 4'b0100;
      f1 = pat[2] | pat[3];
      f2 = pat[1] | pat[3];
      up = !neg_ff;
      fm1 = fm_ff + 1'b1;
      fn1 = f1 ? (up ? fn_ff + 1'b1 : fn_ff - 1'b1) : fn_ff;
      fm2 = fm_ff + 2'd2;
      fn2 = f2 ? (up ? fn1 + 1'b1 : fn1 - 1'b1) : fn1;
      bm1 = bm_ff - 1'b1;
      bn1 = f1 ? (up ? bn_ff - 1'b1 : bn_ff + 1'b1) : bn_ff;
      bm2 = bm_ff - 2'd2;
      bn2 = f2 ? (up ? bn1 - 1'b1 : bn1 + 1'b1) : bn1;
      if (in_data.op == OP_LOAD) begin
         col_in = in_data.color;
         grp_in = '0; tail_in = '0; neg_in = 1'b0;
         dec_in = '0; inc1_in = '0; inc2_in = '0; thr_in = '0;
         if (a1 == a2 || b1 == b2) begin
            swap_in = (a1 == a2);
            if (swap_in) begin
               fn_in = a1;
               fm_in = (b1 < b2) ? b1 : b2;
               bm_in = (b1 < b2) ? b2 : b1;
            end else begin
               fn_in = b1;
               fm_in = (a1 < a2) ? a1 : a2;
               bm_in = (a1 < a2) ? a2 : a1;
            end
            bn_in = fn_in;
            // Straight line: up to two pixels now.
            pix[0] = mk(swap_in, fm_in, fn_in, col_in, fm_in == bm_in);
            if (fm_in == bm_in) begin
               n = 3'd1; mode_in = MODE_IDLE;
            end else begin
               t = fm_in + 1'b1;
               pix[1] = mk(swap_in, t, fn_in, col_in, t == bm_in);
               n = 3'd2;
               if (t == bm_in) mode_in = MODE_IDLE;
               else begin
                  mode_in = MODE_STRAIGHT; fm_in = t + 1'b1;
               end
            end
         end else begin
            dxs = {1'b0, a2} - {1'b0, a1};
            dys = {1'b0, b2} - {1'b0, b1};
            sx = (a2 < a1); sy = (b2 < b1);
            dxa = sx ? -dxs[CoordBits-1:0] : dxs[CoordBits-1:0];
            dya = sy ? -dys[CoordBits-1:0] : dys[CoordBits-1:0];
            neg_in = sx ^ sy;
            swap_in = (dya > dxa);
            if (swap_in) begin
               t = a1; a1 = b1; b1 = t;
               t = a2; a2 = b2; b2 = t;
               t = dxa; dxa = dya; dya = t;
            end
            if (a1 > a2) begin
               fm_in = a2; fn_in = b2; bm_in = a1; bn_in = b1;
            end else begin
               fm_in = a1; fn_in = b1; bm_in = a2; bn_in = b2;
            end
            t = dxa - 1'b1;
            grp_in = t[CoordBits-1:2];
            tail_in = t[1:0];
            d4 = dec_type'({dya, 2'b00});
            i2 = d4 - dec_type'({dxa, 1'b0});
            inc2_in = i2;
            if (i2 < 0) begin
               thr_in = dec_type'({dya, 1'b0});
               mode_in = MODE_SHALLOW;
               dec_in = (thr_in <<< 1) - dec_type'(dxa);
            end else begin
               thr_in = dec_type'({dya, 1'b0}) - dec_type'({dxa, 1'b0});
               mode_in = MODE_STEEP;
               dec_in = (thr_in <<< 1) + dec_type'(dxa);
            end
            inc1_in = thr_in <<< 1;
            fin = (grp_in == '0) && (tail_in == 2'd0);
            pix[0] = mk(swap_in, fm_in, fn_in, col_in, 1'b0);
            pix[1] = mk(swap_in, bm_in, bn_in, col_in, fin);
            n = 3'd2;
            if (fin) mode_in = MODE_IDLE;
         end
      end else if (mode_ff == MODE_STRAIGHT) begin
         // Up to four consecutive coordinates.
         for (int k = 0; k < 4; k++) begin
            if (n == 3'(k) && mode_in == MODE_STRAIGHT) begin
               pix[k] = mk(swap_ff, fm_in, fn_ff, col_ff, fm_in == bm_ff);
               n = 3'(k + 1);
               if (fm_in == bm_ff) mode_in = MODE_IDLE;
               else fm_in = fm_in + 1'b1;
            end
         end
      end else if (mode_ff == MODE_SHALLOW || mode_ff == MODE_STEEP) begin
         if (grp_ff != '0) begin
            grp_in = grp_ff - 1'b1;
            fin = (grp_in == '0) && (tail_ff == 2'd0);
            pix[0] = mk(swap_ff, fm1, fn1, col_ff, 1'b0);
            pix[1] = mk(swap_ff, fm2, fn2, col_ff, 1'b0);
            pix[2] = mk(swap_ff, bm1, bn1, col_ff, 1'b0);
            pix[3] = mk(swap_ff, bm2, bn2, col_ff, fin);
            n = 3'd4;
            fm_in = fm2; fn_in = fn2; bm_in = bm2; bn_in = bn2;
            dec_in = dec_ff + ((pat[0] | pat[3]) ? inc1_ff : inc2_ff);
            if (fin) mode_in = MODE_IDLE;
         end else begin
            if (pat[3]) g = 1'b1;
            else if (pat[2]) g = (mode_ff == MODE_SHALLOW) || (dec_ff > thr_ff);
            dn2 = (tail_ff == 2'd2);
            dn3 = (tail_ff == 2'd1);
            bng = g ? (up ? bn_ff - 1'b1 : bn_ff + 1'b1) : bn_ff;
            pix[0] = mk(swap_ff, fm1, fn1, col_ff, dn3);
            pix[1] = mk(swap_ff, fm2, fn2, col_ff, dn2);
            pix[2] = mk(swap_ff, bm1, bng, col_ff, 1'b1);
            n = {1'b0, tail_ff};
            if (tail_ff != 2'd0) begin
               fm_in = fm1; fn_in = fn1;
            end
            if (tail_ff[1]) begin
               fm_in = fm2; fn_in = fn2;
            end
            if (tail_ff == 2'd3) begin
               bm_in = bm1; bn_in = bng;
            end
            tail_in = 2'd0;
            mode_in = MODE_IDLE;
         end
      end
      for (int k = 0; k < 4; k++) pix[k].last = (n == 3'(k + 1));
   end

   // State and pending buffer registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         fm_ff <= '0; fn_ff <= '0; bm_ff <= '0; bn_ff <= '0;
         dec_ff <= '0; inc1_ff <= '0; inc2_ff <= '0; thr_ff <= '0;
         neg_ff <= 1'b0; swap_ff <= 1'b0; grp_ff <= '0; tail_ff <= '0;
         mode_ff <= MODE_IDLE; col_ff <= '0;
         cnt_ff <= '0; idx_ff <= '0;
      end else begin
         if (take) begin
            fm_ff <= fm_in; fn_ff <= fn_in; bm_ff <= bm_in; bn_ff <= bn_in;
            dec_ff <= dec_in; inc1_ff <= inc1_in; inc2_ff <= inc2_in; thr_ff <= thr_in;
            neg_ff <= neg_in; swap_ff <= swap_in; grp_ff <= grp_in; tail_ff <= tail_in;
            mode_ff <= mode_in; col_ff <= col_in;
            cnt_ff <= n;
            idx_ff <= '0;
            for (int k = 0; k < 4; k++) buf_ff[k] <= pix[k];
         end else if (pop) begin
            cnt_ff <= cnt_ff - 1'b1;
            idx_ff <= idx_ff + 1'b1;
         end
      end
   end

   `CHECK_IMPLY(a_cnt_range, clock, reset, 1'b1, cnt_ff <= 3'd4)
   `CHECK_IMPLY(a_no_take_busy, clock, reset, take, !busy || (pop && cnt_ff == 3'd1))
   `CHECK_NEXT(a_mode_hot, clock, reset, 1'b1, $onehot(mode_ff))
endmodule
`default_nettype wire

[rtl/core/dslr_addr.sv]
// Address stage: forms y*stride+x and holds the result beat.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module dslr_addr (
   input  wire                   clock,
   input  wire                   reset,
   input  wire [dslr_pkg::StrideBits-1:0] stride,
   input  wire                   px_valid,
   input  dslr_pkg::pix_type     px_data,
   output logic                  px_stall,
   output logic                  rsp_valid,
   output dslr_pkg::rsp_type     rsp_data,
   input  wire                   rsp_stall
);
   import dslr_pkg::*;

   logic valid_ff;
   rsp_type data_ff;
   logic [CoordBits+StrideBits-1:0] prod;

   assign prod = px_data.y * stride;
   assign px_stall = valid_ff && rsp_stall;
   assign rsp_valid = valid_ff;
   assign rsp_data = data_ff;

   // Output register, reloaded whenever it is empty or being taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!px_stall) begin
         valid_ff <= px_valid;
         data_ff.pixel_x <= px_data.x;
         data_ff.pixel_y <= px_data.y;
         data_ff.pixel_address <= AddrBits'(prod + (CoordBits+StrideBits)'(px_data.x));
         data_ff.pixel_color <= px_data.color;
         data_ff.last <= px_data.last;
         data_ff.line_done <= px_data.line_done;
      end
   end

   `CHECK_NEXT(a_hold, clock, reset, valid_ff && rsp_stall, valid_ff && $stable(data_ff))
endmodule
`default_nettype wire

[rtl/core/double_step_line_rasterizer.sv]
// A pixel beat passes the walker's pending buffer, then the output register,
// which also takes the address multiply. Throughput: an item emits 0 to 4
// beats, one per cycle unless stalled; the next item is accepted when none is
// pending or in the cycle the last pending beat of the previous one leaves.
// Synchronous reset idles the line and sets stride_ff to STRIDE_RESET (320).
`timescale 1ns / 1ps
`default_nettype none
module double_step_line_rasterizer #(
   parameter int STRIDE_RESET = 320
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   input  dslr_pkg::req_type     req_data,
   output logic                  req_stall,
   output logic                  rsp_valid,
   output dslr_pkg::rsp_type     rsp_data,
   input  wire                   rsp_stall,
   input  wire                   csr_valid,
   input  wire [dslr_pkg::StrideBits-1:0] csr_data,
   output logic                  csr_ready
);
   import dslr_pkg::*;

   logic [StrideBits-1:0] stride_ff;
   logic px_valid, px_stall;
   pix_type px_data;

   assign csr_ready = 1'b1;

   // Row stride register.
   always_ff @(posedge clock) begin
      if (reset) begin
         stride_ff <= StrideBits'(STRIDE_RESET);
      end else if (csr_valid) begin
         stride_ff <= csr_data;
      end
   end

   dslr_step u_step (
      .clock(clock), .reset(reset),
      .in_valid(req_valid), .in_data(req_data), .in_stall(req_stall),
      .px_valid(px_valid), .px_data(px_data), .px_stall(px_stall)
   );

   dslr_addr u_addr (
      .clock(clock), .reset(reset), .stride(stride_ff),
      .px_valid(px_valid), .px_data(px_data), .px_stall(px_stall),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .rsp_stall(rsp_stall)
   );
endmodule
`default_nettype wire

[test/line_pixel_checker.sv]
// Checker that predicts and compares the pixel beats of the line rasterizer.
`timescale 1ns / 1ps
`default_nettype none
module line_pixel_checker (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   input  dslr_pkg::req_type    req_data,
   input  wire                  req_stall,
   input  wire                  rsp_valid,
   input  dslr_pkg::rsp_type    rsp_data,
   input  wire                  rsp_stall,
   input  wire                  csr_valid,
   input  wire [dslr_pkg::StrideBits-1:0] csr_data,
   input  wire                  csr_ready,
   output int                   fail_count,
   output int                   pending_count
);
   import dslr_pkg::*;

   localparam logic [CoordBits-1:0] CoordOne = 1;

   // Predicted line state.
   logic [StrideBits-1:0] stride;
   logic [CoordBits-1:0]  f_maj, f_min, b_maj, b_min;
   int                    dec, inc1, inc2, thr;
   logic                  neg_step, swapped;
   int                    groups, tail;
   mode_type              mode;
   logic [ColorBits-1:0]  line_col;

   rsp_type pixel_queue[$];
   rsp_type batch[$];

   assign pending_count = pixel_queue.size();

   task automatic report_mismatch(input string what);
      $display("mismatch: %s", what);
      fail_count++;
   endtask

   // Queue one predicted pixel in screen coordinates.
   task automatic push_pixel(input logic [CoordBits-1:0] maj, input logic [CoordBits-1:0] mnr,
                             input logic done);
      rsp_type p;
      logic [63:0] addr;
      p.pixel_x = swapped ? mnr : maj;
      p.pixel_y = swapped ? maj : mnr;
      addr = 64'(p.pixel_y) * 64'(stride) + 64'(p.pixel_x);
      p.pixel_address = addr[AddrBits-1:0];
      p.pixel_color = line_col;
      p.last = 1'b0;
      p.line_done = done;
      batch.push_back(p);
   endtask

   function automatic logic [CoordBits-1:0] step_minor(input logic [CoordBits-1:0] v,
                                                        input logic fwd, input logic amt);
      logic down;
      down = (neg_step != !fwd);
      if (!amt) return v;
      return down ? v - CoordOne : v + CoordOne;
   endfunction

   task automatic emit_straight(input int limit);
      int n;
      logic done;
      n = 0;
      while (n < limit && mode == MODE_STRAIGHT) begin
         done = (f_maj == b_maj);
         push_pixel(f_maj, f_min, done);
         n++;
         if (done) mode = MODE_IDLE;
         else f_maj = f_maj + CoordOne;
      end
   endtask

   task automatic load_line(input req_type r);
      int a1, b1, a2, b2, dx, dy, t;
      logic sx, sy;
      a1 = r.x_start; b1 = r.y_start; a2 = r.x_end; b2 = r.y_end;
      line_col = r.color;
      groups = 0; tail = 0; dec = 0; inc1 = 0; inc2 = 0; thr = 0;
      neg_step = 1'b0;
      if (a1 == a2 || b1 == b2) begin
         swapped = (a1 == a2);
         if (swapped) begin
            f_min = a1; f_maj = (b1 < b2) ? b1 : b2; b_maj = (b1 < b2) ? b2 : b1;
         end else begin
            f_min = b1; f_maj = (a1 < a2) ? a1 : a2; b_maj = (a1 < a2) ? a2 : a1;
         end
         b_min = f_min;
         mode = MODE_STRAIGHT;
         return;
      end
      dx = a2 - a1; dy = b2 - b1;
      sx = dx < 0; sy = dy < 0;
      if (sx) dx = -dx;
      if (sy) dy = -dy;
      neg_step = (sx != sy);
      swapped = dy > dx;
      if (swapped) begin
         t = a1; a1 = b1; b1 = t;
         t = a2; a2 = b2; b2 = t;
         t = dx; dx = dy; dy = t;
      end
      if (a1 > a2) begin
         f_maj = a2; f_min = b2; b_maj = a1; b_min = b1;
      end else begin
         f_maj = a1; f_min = b1; b_maj = a2; b_min = b2;
      end
      groups = (dx - 1) / 4;
      tail = (dx - 1) % 4;
      inc2 = 4 * dy - 2 * dx;
      if (inc2 < 0) begin
         thr = 2 * dy; inc1 = 2 * thr; dec = inc1 - dx; mode = MODE_SHALLOW;
      end else begin
         thr = 2 * (dy - dx); inc1 = 2 * thr; dec = inc1 + dx; mode = MODE_STEEP;
      end
   endtask

   // Patterns: 1 flat-flat, 2 flat-step, 3 step-flat, 4 step-step.
   task automatic advance_general();
      int p, g;
      logic f1, f2, fin;
      if (mode == MODE_SHALLOW && dec < 0) p = 1;
      else if (mode == MODE_STEEP && dec > 0) p = 4;
      else p = (dec < thr) ? 2 : 3;
      f1 = (p == 3 || p == 4);
      f2 = (p == 2 || p == 4);
      if (groups > 0) begin
         groups--;
         fin = (groups == 0 && tail == 0);
         f_maj = f_maj + CoordOne; f_min = step_minor(f_min, 1'b1, f1);
         push_pixel(f_maj, f_min, 1'b0);
         f_maj = f_maj + CoordOne; f_min = step_minor(f_min, 1'b1, f2);
         push_pixel(f_maj, f_min, 1'b0);
         b_maj = b_maj - CoordOne; b_min = step_minor(b_min, 1'b0, f1);
         push_pixel(b_maj, b_min, 1'b0);
         b_maj = b_maj - CoordOne; b_min = step_minor(b_min, 1'b0, f2);
         push_pixel(b_maj, b_min, fin);
         dec += (p == 1 || p == 4) ? inc1 : inc2;
         if (fin) mode = MODE_IDLE;
         return;
      end
      if (tail > 0) begin
         g = 0;
         if (p == 4) g = 1;
         else if (p == 3) g = (mode == MODE_SHALLOW || dec > thr) ? 1 : 0;
         f_maj = f_maj + CoordOne; f_min = step_minor(f_min, 1'b1, f1);
         push_pixel(f_maj, f_min, tail == 1);
         if (tail > 1) begin
            f_maj = f_maj + CoordOne; f_min = step_minor(f_min, 1'b1, f2);
            push_pixel(f_maj, f_min, tail == 2);
         end
         if (tail > 2) begin
            b_maj = b_maj - CoordOne; b_min = step_minor(b_min, 1'b0, g[0]);
            push_pixel(b_maj, b_min, 1'b1);
         end
         tail = 0;
      end
      mode = MODE_IDLE;
   endtask

   // Predict all pixels of one accepted item.
   task automatic predict_item(input req_type r);
      logic fin;
      batch.delete();
      if (r.op == OP_LOAD) begin
         load_line(r);
         if (mode == MODE_STRAIGHT) begin
            emit_straight(2);
         end else begin
            fin = (groups == 0 && tail == 0);
            push_pixel(f_maj, f_min, 1'b0);
            push_pixel(b_maj, b_min, fin);
            if (fin) mode = MODE_IDLE;
         end
      end else if (mode == MODE_STRAIGHT) begin
         emit_straight(4);
      end else if (mode == MODE_SHALLOW || mode == MODE_STEEP) begin
         advance_general();
      end
      if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
      foreach (batch[i]) pixel_queue.push_back(batch[i]);
   endtask

   // Watch all three channels at each rising edge.
   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         stride = 320;
         f_maj = 0; f_min = 0; b_maj = 0; b_min = 0;
         dec = 0; inc1 = 0; inc2 = 0; thr = 0;
         neg_step = 0; swapped = 0; groups = 0; tail = 0;
         mode = MODE_IDLE; line_col = 0;
         fail_count = 0;
         pixel_queue.delete();
      end else begin
         if (csr_valid && csr_ready) stride = csr_data;
         if (req_valid && !req_stall) predict_item(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (pixel_queue.size() == 0) begin
               report_mismatch($sformatf("unexpected beat %p", rsp_data));
            end else begin
               e = pixel_queue.pop_front();
               if (rsp_data.pixel_x !== e.pixel_x)
                  report_mismatch($sformatf("pixel_x %0d, want %0d", rsp_data.pixel_x, e.pixel_x));
               if (rsp_data.pixel_y !== e.pixel_y)
                  report_mismatch($sformatf("pixel_y %0d, want %0d", rsp_data.pixel_y, e.pixel_y));
               if (rsp_data.pixel_address !== e.pixel_address)
                  report_mismatch($sformatf("address %0d, want %0d",
                                            rsp_data.pixel_address, e.pixel_address));
               if (rsp_data.pixel_color !== e.pixel_color)
                  report_mismatch($sformatf("color %0d, want %0d",
                                            rsp_data.pixel_color, e.pixel_color));
               if (rsp_data.last !== e.last)
                  report_mismatch($sformatf("last %b, want %b", rsp_data.last, e.last));
               if (rsp_data.line_done !== e.line_done)
                  report_mismatch($sformatf("line_done %b, want %b",
                                            rsp_data.line_done, e.line_done));
            end
         end
      end
   end
endmodule
`default_nettype wire

[test/tb.sv]
// Testbench top: stimulus, idling phases and verdict for the line rasterizer.
`timescale 1ns / 1ps
`default_nettype none
module tb;
   import dslr_pkg::*;

   localparam int WatchLimit = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   req_type req_data = '0;
   logic req_stall;
   logic rsp_valid;
   rsp_type rsp_data;
   logic rsp_stall = 1'b0;
   logic csr_valid = 1'b0;
   logic [StrideBits-1:0] csr_data = '0;
   logic csr_ready;
   int fail_count;
   int pending_count;

   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_cycles = 0;
   int quiet_cycles = 0;

   always #1 clock = ~clock;

   double_step_line_rasterizer dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_data(req_data), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .rsp_stall(rsp_stall),
      .csr_valid(csr_valid), .csr_data(csr_data), .csr_ready(csr_ready)
   );

   line_pixel_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_data(req_data), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .rsp_stall(rsp_stall),
      .csr_valid(csr_valid), .csr_data(csr_data), .csr_ready(csr_ready),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   // Receiver stalls at random, or holds off for a long counted stretch.
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   // Watchdog on cycles with no beat accepted on any channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WatchLimit) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   // Offer one beat, with random idle cycles before it. Valid stays high
   // after acceptance until the next beat or an idle cycle replaces it.
   task automatic send_beat(input req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   function automatic req_type make_load(input int xs, input int ys, input int xe,
                                         input int ye, input int col);
      req_type r;
      r.op = OP_LOAD;
      r.x_start = xs; r.y_start = ys; r.x_end = xe; r.y_end = ye;
      r.color = col;
      return r;
   endfunction

   function automatic req_type make_advance();
      req_type r;
      r = req_type'({$urandom, $urandom});
      r.op = OP_ADVANCE;
      return r;
   endfunction

   // Random line: mostly short, some full range, some straight.
   function automatic req_type random_line();
      int xs, ys, span, kind;
      req_type r;
      kind = $urandom_range(9);
      span = (kind < 6) ? 24 : 2047;
      xs = $urandom_range(2047); ys = $urandom_range(2047);
      r = make_load(xs, ys, xs, ys, $urandom_range(255));
      if (kind == 9) begin
         r = req_type'({$urandom, $urandom});
         r.op = OP_LOAD;
         return r;
      end
      r.x_end = (kind == 8) ? xs : (xs + $urandom_range(span)) % 2048;
      r.y_end = (kind == 7) ? ys : (ys + $urandom_range(span)) % 2048;
      if ($urandom_range(1)) begin
         r.x_end = xs; r.x_start = (xs + $urandom_range(span)) % 2048;
      end
      return r;
   endfunction

   task automatic write_stride(input int value);
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   // Wait until all predicted beats are out, then let the pipeline drain.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Random lines, each followed by advances, a few cut short by a new load.
   task automatic random_lines(input int items);
      int sent, steps;
      sent = 0;
      while (sent < items) begin
         send_beat(random_line());
         sent++;
         steps = $urandom_range(6) == 0 ? $urandom_range(2) : $urandom_range(12);
         repeat (steps) begin
            send_beat(make_advance());
            sent++;
         end
      end
   endtask

   initial begin
      int strides[5];
      strides = '{1, 2048 % 4096, 4095, 640, 0};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, straight lines, single point, octants, idle advance.
      send_beat(make_advance());
      send_beat(make_load(5, 5, 5, 5, 255));
      send_beat(make_advance());
      send_beat(make_load(0, 0, 2047, 2047, 0));
      send_beat(make_load(2047, 2047, 0, 0, 170));
      send_beat(make_load(3, 10, 3, 2, 85));
      repeat (3) send_beat(make_advance());
      send_beat(make_load(9, 7, 0, 7, 1));
      repeat (3) send_beat(make_advance());
      send_beat(make_load(0, 0, 10, 3, 2));
      repeat (3) send_beat(make_advance());
      send_beat(make_load(10, 0, 0, 9, 3));
      repeat (3) send_beat(make_advance());
      send_beat(make_load(0, 2047, 2047, 0, 4));
      send_beat(make_load(1, 1, 2, 2, 5));
      drain();

      // Random phases with different strides and idling.
      for (int ph = 0; ph < 5; ph++) begin
         write_stride(strides[ph]);
         case (ph)
            1: begin send_idle_pct = 83; stall_pct = 0; end
            2: begin send_idle_pct = 0; stall_pct = 83; end
            3: begin send_idle_pct = 10; stall_pct = 10; end
            default: begin send_idle_pct = 0; stall_pct = 0; end
         endcase
         if (ph == 4) hold_cycles <= 300;
         random_lines(30);
         drain();
      end

      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule
`default_nettype wire
